// ===== rtl/r2fft_pkg.sv =====
package r2fft_pkg;

  localparam int StoreW = 24;
  localparam int RomFrac = 24;
  // butterfly product term after rounding: 24-bit sample times Q1.x twiddle, plus carry
  localparam int TermW = StoreW + 3;

  localparam logic [1:0] REG_LOG2_LENGTH = 2'd0;
  localparam logic [1:0] REG_INVERSE_SIGN = 2'd1;

  typedef struct packed {
    logic mul_en;
    logic add_en;
  } bf_ctrl_t;

  // quarter-wave cosine, cos(pi k / 32) in Q1.24, k = 0..16
  function automatic logic [RomFrac:0] cos_rom(input logic [4:0] k);
    logic [RomFrac:0] v;
    unique case (k)
      5'd0:    v = 25'd16777216;
      5'd1:    v = 25'd16696429;
      5'd2:    v = 25'd16454846;
      5'd3:    v = 25'd16054795;
      5'd4:    v = 25'd15500126;
      5'd5:    v = 25'd14796184;
      5'd6:    v = 25'd13949745;
      5'd7:    v = 25'd12968963;
      5'd8:    v = 25'd11863283;
      5'd9:    v = 25'd10643353;
      5'd10:   v = 25'd9320922;
      5'd11:   v = 25'd7908725;
      5'd12:   v = 25'd6420363;
      5'd13:   v = 25'd4870169;
      5'd14:   v = 25'd3273072;
      5'd15:   v = 25'd1644455;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [StoreW-1:0] sat_store(input logic signed [TermW:0] v);
    logic signed [StoreW-1:0] r;
    if (v > 28'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -28'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[StoreW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/r2fft_bfly.sv =====
module r2fft_bfly #(
  parameter int TWIDDLE_FRAC_BITS = 17
) (
  input  logic                                 clk_i,
  input  r2fft_pkg::bf_ctrl_t                  ctrl_i,
  input  logic signed [23:0]                   b_re_i,
  input  logic signed [23:0]                   b_im_i,
  input  logic signed [TWIDDLE_FRAC_BITS+1:0]  w_re_i,
  input  logic signed [TWIDDLE_FRAC_BITS+1:0]  w_im_i,
  output logic signed [r2fft_pkg::TermW-1:0]   t_re_o,
  output logic signed [r2fft_pkg::TermW-1:0]   t_im_o
);
  import r2fft_pkg::*;

  localparam int TW = TWIDDLE_FRAC_BITS + 2;
  localparam int PW = StoreW + TW;
  localparam logic signed [PW:0] Rnd = (PW + 1)'(1) <<< (TWIDDLE_FRAC_BITS - 1);

  logic signed [PW-1:0] rr_q, ii_q, ri_q, ir_q;
  logic signed [PW:0]   sum_re, sum_im;
  logic signed [TermW-1:0] t_re_q, t_im_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      rr_q <= PW'(b_re_i * w_re_i);
      ii_q <= PW'(b_im_i * w_im_i);
      ri_q <= PW'(b_re_i * w_im_i);
      ir_q <= PW'(b_im_i * w_re_i);
    end
  end

  // round half up to the sample scale
  assign sum_re = (PW + 1)'(rr_q) - (PW + 1)'(ii_q) + Rnd;
  assign sum_im = (PW + 1)'(ri_q) + (PW + 1)'(ir_q) + Rnd;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.add_en) begin
      t_re_q <= sum_re[TWIDDLE_FRAC_BITS +: TermW];
      t_im_q <= sum_im[TWIDDLE_FRAC_BITS +: TermW];
    end
  end

  assign t_re_o = t_re_q;
  assign t_im_o = t_im_q;

endmodule

// ===== rtl/radix2_complex_fft_top.sv =====
// channel  | signals                                  | direction
// input    | in_valid_i, in_stall_o, in_real_i/imag_i | sample in
// output   | out_valid_o, out_stall_i, out_*_o        | bin out, last marked
// config   | cfg_valid_i, cfg_ready_o, cfg_index_i    | register write
//
// one sample is taken per cycle while loading; the input stalls from the last
// sample of a frame until the final bin sits in the output register
// each butterfly reads both operands in turn on the single read port of the
// work memory, (N/2)*log2(N) butterflies per frame
// reset clears the control state only; the work memory is written before read
module radix2_complex_fft_top #(
  parameter int MAX_POINTS        = 64,
  parameter int SAMPLE_BITS       = 16,
  parameter int TWIDDLE_FRAC_BITS = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] in_real_i,
  input  logic signed [SAMPLE_BITS-1:0] in_imag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [23:0]            out_real_o,
  output logic signed [23:0]            out_imag_o,
  output logic                          out_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [2:0]                    cfg_data_i
);
  import r2fft_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS + 1) - 1;
  localparam int DEPTH = 1 << AW;
  localparam int TW    = TWIDDLE_FRAC_BITS + 2;
  localparam int SH    = RomFrac - TWIDDLE_FRAC_BITS;
  localparam logic [RomFrac+1:0] RomRnd = ((RomFrac + 2)'(1) << SH) >> 1;

  typedef enum logic [8:0] {
    S_LOAD = 9'b000000001,
    S_RA   = 9'b000000010,
    S_RB   = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_ADD  = 9'b000010000,
    S_WA   = 9'b000100000,
    S_WB   = 9'b001000000,
    S_ORD  = 9'b010000000,
    S_OCAP = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic                 out_wait_q, out_wait_d;
  logic [2:0]           log2_q, log2_d;
  logic                 inv_q, inv_d;
  logic [AW-1:0]        load_cnt_q, load_cnt_d;
  logic [2:0]           lm_q, lm_d;
  logic [AW-1:0]        bidx_q, bidx_d;
  logic [AW-1:0]        kout_q, kout_d;

  logic [2:0]           l_eff;
  logic [AW:0]          n_pts;
  logic [AW-1:0]        n_m1, half_m1;
  logic [AW-1:0]        rev, dst;
  logic [AW-1:0]        mask, m_bit, addr_a, addr_b;
  logic [5:0]           tw_idx;
  logic [1:0]           quad;
  logic [3:0]           rem;
  logic [RomFrac+1:0]   rnd_a, rnd_b;
  logic signed [TW-1:0] tw_a, tw_b, c_w, s_w;
  logic signed [TW-1:0] wr_q, wi_q;
  logic signed [23:0]   a_re_q, a_im_q;
  logic signed [TermW-1:0] t_re, t_im;

  logic [47:0]          mem [DEPTH];
  logic [47:0]          rd_q;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [47:0]          wdata;

  logic                 in_fire, cfg_fire, out_fire;
  logic signed [23:0]   out_real_q, out_imag_q;
  logic                 out_last_q;
  bf_ctrl_t             bf_ctrl;

  // effective length, at least 2 points and clamped to what the memory holds
  always_comb begin
    if (log2_q == 3'd0) begin
      l_eff = 3'd1;
    end else if (log2_q > 3'(AW)) begin
      l_eff = 3'(AW);
    end else begin
      l_eff = log2_q;
    end
  end

  assign n_pts   = (AW + 1)'(1) << l_eff;
  assign n_m1    = AW'(n_pts - (AW + 1)'(1));
  assign half_m1 = AW'((n_pts >> 1) - (AW + 1)'(1));

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      rev[i] = load_cnt_q[AW-1-i];
    end
  end
  assign dst = rev >> (3'(AW) - l_eff);

  // butterfly addressing: group base from the upper index bits, offset from the lower
  assign mask   = AW'((AW + 1)'(1) << lm_q) - AW'(1);
  assign m_bit  = AW'((AW + 1)'(1) << lm_q);
  assign addr_a = ((bidx_q >> lm_q) << (lm_q + 3'd1)) | (bidx_q & mask);
  assign addr_b = addr_a | m_bit;
  assign tw_idx = 6'(bidx_q & mask) << (3'd5 - lm_q);

  assign quad  = tw_idx[5:4];
  assign rem   = tw_idx[3:0];
  assign rnd_a = ((RomFrac + 2)'(cos_rom({1'b0, rem})) + RomRnd) >> SH;
  assign rnd_b = ((RomFrac + 2)'(cos_rom(5'd16 - {1'b0, rem})) + RomRnd) >> SH;
  assign tw_a  = TW'(rnd_a);
  assign tw_b  = TW'(rnd_b);

  always_comb begin
    unique case (quad)
      2'd0:    begin c_w = tw_a;  s_w = tw_b;  end
      2'd1:    begin c_w = -tw_b; s_w = tw_a;  end
      2'd2:    begin c_w = -tw_a; s_w = -tw_b; end
      default: begin c_w = tw_b;  s_w = -tw_a; end
    endcase
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign cfg_ready_o = (state_q == S_LOAD);
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign out_valid_o = out_wait_q;
  assign out_fire    = out_wait_q & ~out_stall_i;

  assign bf_ctrl.mul_en = (state_q == S_MUL);
  assign bf_ctrl.add_en = (state_q == S_ADD);

  r2fft_bfly #(
    .TWIDDLE_FRAC_BITS(TWIDDLE_FRAC_BITS)
  ) u_bfly (
    .clk_i  (clk_i),
    .ctrl_i (bf_ctrl),
    .b_re_i (rd_q[47:24]),
    .b_im_i (rd_q[23:0]),
    .w_re_i (wr_q),
    .w_im_i (wi_q),
    .t_re_o (t_re),
    .t_im_o (t_im)
  );

  always_comb begin
    state_d    = state_q;
    out_wait_d = out_wait_q;
    log2_d     = log2_q;
    inv_d      = inv_q;
    load_cnt_d = load_cnt_q;
    lm_d       = lm_q;
    bidx_d     = bidx_q;
    kout_d     = kout_q;
    we         = 1'b0;
    waddr      = addr_a;
    wdata      = {sat_store((TermW + 1)'(a_re_q) + (TermW + 1)'(t_re)),
                  sat_store((TermW + 1)'(a_im_q) + (TermW + 1)'(t_im))};
    raddr      = addr_a;
    unique case (state_q)
      S_LOAD: begin
        if (cfg_fire) begin
          if (cfg_index_i == REG_LOG2_LENGTH) begin
            log2_d     = cfg_data_i;
            load_cnt_d = '0;
          end else if (cfg_index_i == REG_INVERSE_SIGN) begin
            inv_d = cfg_data_i[0];
          end
        end
        if (in_fire) begin
          we    = 1'b1;
          waddr = dst;
          wdata = {24'(in_real_i), 24'(in_imag_i)};
          if (load_cnt_q == n_m1) begin
            load_cnt_d = '0;
            lm_d       = '0;
            bidx_d     = '0;
            state_d    = S_RA;
          end else begin
            load_cnt_d = load_cnt_q + AW'(1);
          end
        end
      end
      S_RA:  state_d = S_RB;
      S_RB: begin
        raddr   = addr_b;
        state_d = S_MUL;
      end
      S_MUL: state_d = S_ADD;
      S_ADD: state_d = S_WA;
      S_WA: begin
        we      = 1'b1;
        state_d = S_WB;
      end
      S_WB: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = {sat_store((TermW + 1)'(a_re_q) - (TermW + 1)'(t_re)),
                 sat_store((TermW + 1)'(a_im_q) - (TermW + 1)'(t_im))};
        if (bidx_q == half_m1) begin
          bidx_d = '0;
          if (lm_q == l_eff - 3'd1) begin
            kout_d  = '0;
            state_d = S_ORD;
          end else begin
            lm_d    = lm_q + 3'd1;
            state_d = S_RA;
          end
        end else begin
          bidx_d  = bidx_q + AW'(1);
          state_d = S_RA;
        end
      end
      S_ORD: begin
        raddr = kout_q;
        if (!out_wait_q) begin
          state_d = S_OCAP;
        end
      end
      S_OCAP: begin
        out_wait_d = 1'b1;
        if (kout_q == n_m1) begin
          state_d = S_LOAD;
        end else begin
          kout_d  = kout_q + AW'(1);
          state_d = S_ORD;
        end
      end
      default: state_d = S_LOAD;
    endcase
    // a bin taken frees the output register
    if (out_fire) begin
      out_wait_d = (state_q == S_OCAP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      out_wait_q <= 1'b0;
      log2_q     <= 3'd6;
      inv_q      <= 1'b0;
      load_cnt_q <= '0;
      lm_q       <= '0;
      bidx_q     <= '0;
      kout_q     <= '0;
    end else begin
      state_q    <= state_d;
      out_wait_q <= out_wait_d;
      log2_q     <= log2_d;
      inv_q      <= inv_d;
      load_cnt_q <= load_cnt_d;
      lm_q       <= lm_d;
      bidx_q     <= bidx_d;
      kout_q     <= kout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RA) begin
      wr_q <= c_w;
      wi_q <= inv_q ? s_w : -s_w;
    end
    if (state_q == S_RB) begin
      a_re_q <= rd_q[47:24];
      a_im_q <= rd_q[23:0];
    end
    if (state_q == S_OCAP) begin
      out_real_q <= rd_q[47:24];
      out_imag_q <= rd_q[23:0];
      out_last_q <= (kout_q == n_m1);
    end
  end

  assign out_real_o = out_real_q;
  assign out_imag_o = out_imag_q;
  assign out_last_o = out_last_q;

`ifndef NO_ASSERTIONS
  a_cnt_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= n_m1)
    else $error("load count beyond frame length");

  a_frame_starts_bfly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && load_cnt_q == n_m1 |=> state_q == S_RA && lm_q == 3'd0)
    else $error("full frame did not start the butterflies");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_last_o |=> !out_valid_o)
    else $error("frame not closed after last bin");

  a_no_write_in_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_stall_o |-> out_last_o)
    else $error("input reopened before final bin");
`endif

endmodule
